[rtl/tdb_pkg.sv]
// Shared constants for the thresholded distance-to-best block.
// Used by the top level, thresholded_distance_to_best; depends on nothing.
package tdb_pkg;

  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int MAX_VARS_DEF       = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 40;
  localparam int OUT_IDX_W  = 6;
  localparam int VPC_W      = 5;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VPC      = 2'd3;

  localparam logic [MODE_W-1:0] THR_BEST = 2'd0;
  localparam logic [MODE_W-1:0] THR_MEAN = 2'd1;
  localparam logic [MODE_W-1:0] THR_OWN  = 2'd2;

endpackage

[rtl/tdb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tdb_isqrt.sv]
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// No dependencies.
module tdb_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= operand;
        res  <= '0;
        bitm <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/thresholded_distance_to_best.sv]
// Top level: candidate loader, best search, threshold test and distance sequencer.
// Depends on tdb_pkg, tdb_ram and tdb_isqrt.
//
//   channel   | direction | payload
//   s_*       | in        | s_tdata: objective, var_value; s_tlast: last_candidate
//   m_*       | out       | m_tdata: cand_index, distance; m_tuser: passed; m_tlast: last
//   cfg_*     | in        | register index and write data
//
// Loading takes one variable per cycle while the block is in its load state. After the
// final candidate the block runs the best search, then the mean divide in mean mode or
// the threshold read in best mode, and per candidate the threshold test and, if it passes,
// the distance sum and the square-root unit.
// Each result waits in its output register until taken; no request is taken meanwhile.
// Reset is synchronous; the stores need no clearing pass.
module thresholded_distance_to_best #(
  parameter int MAX_CANDIDATES = tdb_pkg::MAX_CANDIDATES_DEF,
  parameter int MAX_VARS       = tdb_pkg::MAX_VARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,  // objective, var_value
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,  // cand_index, distance, zero pad
  output logic [0:0]                     m_tuser,  // passed
  output logic                           m_tlast
);
  import tdb_pkg::*;

  localparam int IW    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW    = $clog2(MAX_CANDIDATES + 1);
  localparam int PW    = $clog2(MAX_VARS);
  localparam int VW    = $clog2(MAX_VARS + 1);
  localparam int DEPTH = MAX_CANDIDATES * MAX_VARS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_LOAD, S_BEST_RD, S_BEST_CMP, S_THR_RD, S_THR_GET, S_DIV, S_DIV_END,
    S_OBJ_RD, S_OBJ_GET, S_MUL, S_TEST, S_VB_RD, S_VC_RD, S_VC_GET, S_SQ,
    S_ACC, S_ROOT, S_ROOT_WAIT, S_OUT
  } state_t;

  state_t state;

  logic                    maximize;
  logic signed [VAL_W-1:0] shift_value;
  logic [MODE_W-1:0]       thr_mode;
  logic [VPC_W-1:0]        vars_per_candidate;

  logic [CW-1:0]           count;
  logic [PW-1:0]           vpos;
  logic [SUM_W-1:0]        tsum;
  logic [IW-1:0]           best;
  logic [IW-1:0]           cidx;
  logic [PW-1:0]           vidx;
  logic [VAL_W-1:0]        bobj;
  logic signed [VAL_W-1:0] thr;
  logic signed [32:0]      a_val;
  logic signed [VAL_W-1:0] t_val;
  logic signed [64:0]      prod;
  logic [VAL_W-1:0]        bvar;
  logic [31:0]             mag;
  logic [63:0]             sq;
  logic [63:0]             acc;
  logic                    sat;
  logic [SUM_W-1:0]        dq;
  logic [7:0]              drem;
  logic [5:0]              dcnt;
  logic                    dneg;
  logic [OUT_IDX_W-1:0]    out_idx;
  logic [31:0]             out_dist;
  logic                    out_pass;
  logic                    out_last;

  logic [31:0]             vpc32;
  logic [VW-1:0]           nv;
  logic [VW-1:0]           nvm1;
  logic [VW-1:0]           pos;
  logic                    stored;
  logic                    final_var;
  logic                    accept;
  logic                    obj_we;
  logic                    var_we;
  logic [IW-1:0]           obj_raddr;
  logic [AW-1:0]           var_waddr;
  logic [AW-1:0]           var_raddr;
  logic [VAL_W-1:0]        obj_rdata;
  logic [VAL_W-1:0]        var_rdata;
  logic signed [32:0]      b_val;
  logic signed [64:0]      a16;
  logic signed [64:0]      b16;
  logic                    pass;
  logic                    better;
  logic                    last_c;
  logic signed [32:0]      diff;
  logic [64:0]             acc_sum;
  logic [7:0]              dtry;
  logic                    root_start;
  logic [31:0]             root;
  logic                    root_done;

  function automatic logic [AW-1:0] vaddr(input logic [IW-1:0] c, input logic [VW-1:0] p);
    return AW'(32'(c) * MAX_VARS + 32'(p));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      maximize           <= 1'b0;
      shift_value        <= '0;
      thr_mode           <= THR_BEST;
      vars_per_candidate <= VPC_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAXIMIZE: maximize           <= cfg_data[0];
        REG_SHIFT:    shift_value        <= cfg_data;
        REG_THR_MODE: thr_mode           <= cfg_data[MODE_W-1:0];
        REG_VPC:      vars_per_candidate <= cfg_data[VPC_W-1:0];
        default:      maximize           <= maximize;
      endcase
    end
  end

  assign vpc32     = 32'(vars_per_candidate);
  assign nv        = (vpc32 < 32'd2) ? VW'(2) :
                     (vpc32 > 32'(MAX_VARS)) ? VW'(MAX_VARS) : VW'(vpc32);
  assign nvm1      = nv - VW'(1);
  assign pos       = (VW'(vpos) >= nv) ? nvm1 : VW'(vpos);
  assign stored    = 32'(count) < 32'(MAX_CANDIDATES);
  assign final_var = (pos == nvm1);
  assign s_tready  = (state == S_LOAD);
  assign accept    = s_tvalid && s_tready;
  assign obj_we    = accept && stored && (pos == '0);
  assign var_we    = accept && stored;
  assign var_waddr = vaddr(count[IW-1:0], pos);
  assign obj_raddr = cidx;

  always_comb begin
    unique case (state)
      S_THR_RD: var_raddr = vaddr(best, nvm1);
      S_VB_RD:  var_raddr = vaddr(best, VW'(vidx));
      S_VC_RD:  var_raddr = vaddr(cidx, VW'(vidx));
      default:  var_raddr = vaddr(cidx, nvm1);
    endcase
  end

  tdb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CANDIDATES)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(count[IW-1:0]), .wdata(s_tdata[31:0]),
    .raddr(obj_raddr), .rdata(obj_rdata)
  );

  tdb_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_var_ram (
    .clk(clk), .we(var_we), .waddr(var_waddr), .wdata(s_tdata[63:32]),
    .raddr(var_raddr), .rdata(var_rdata)
  );

  assign root_start = (state == S_ROOT) && !sat;

  tdb_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(root_start), .operand(acc),
    .root(root), .done(root_done)
  );

  assign better = maximize ? ($signed(obj_rdata) > $signed(bobj))
                           : ($signed(obj_rdata) < $signed(bobj));
  assign last_c = (32'(cidx) + 32'd1 == 32'(count));
  assign b_val  = 33'($signed(bobj)) - 33'(shift_value);
  assign a16    = $signed({{16{a_val[32]}}, a_val, 16'b0});
  assign b16    = $signed({{16{b_val[32]}}, b_val, 16'b0});
  assign diff   = 33'($signed(bvar)) - 33'($signed(var_rdata));
  assign acc_sum = {1'b0, acc} + {1'b0, sq};
  assign dtry   = {drem[6:0], dq[SUM_W-1]};

  always_comb begin
    if (maximize) begin
      pass = (a16 >= prod);
    end else if (t_val == '0) begin
      pass = 1'b0;
    end else if (!t_val[VAL_W-1]) begin
      pass = (prod <= b16);
    end else begin
      pass = (prod >= b16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      vpos  <= '0;
      tsum  <= '0;
      best  <= '0;
      cidx  <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (final_var) begin
              vpos <= '0;
              if (stored) begin
                count <= count + CW'(1);
                tsum  <= tsum + {{(SUM_W-VAL_W){s_tdata[63]}}, s_tdata[63:32]};
              end
              if (s_tlast) begin
                cidx  <= '0;
                state <= S_BEST_RD;
              end
            end else begin
              vpos <= PW'(pos + VW'(1));
            end
          end
        end
        S_BEST_RD: state <= S_BEST_CMP;
        S_BEST_CMP: begin
          if (cidx == '0 || better) begin
            best <= cidx;
            bobj <= obj_rdata;
          end
          if (last_c) begin
            cidx <= '0;
            priority if (thr_mode == THR_MEAN) begin
              dq    <= tsum[SUM_W-1] ? -tsum : tsum;
              dneg  <= tsum[SUM_W-1];
              drem  <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end else if (thr_mode == THR_OWN) begin
              state <= S_OBJ_RD;
            end else begin
              state <= S_THR_RD;
            end
          end else begin
            cidx  <= cidx + IW'(1);
            state <= S_BEST_RD;
          end
        end
        S_THR_RD: state <= S_THR_GET;
        S_THR_GET: begin
          thr   <= var_rdata;
          state <= S_OBJ_RD;
        end
        S_DIV: begin
          if (dtry >= 8'(count)) begin
            drem <= dtry - 8'(count);
            dq   <= {dq[SUM_W-2:0], 1'b1};
          end else begin
            drem <= dtry;
            dq   <= {dq[SUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(SUM_W - 1)) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          thr   <= dneg ? -dq[VAL_W-1:0] : dq[VAL_W-1:0];
          state <= S_OBJ_RD;
        end
        S_OBJ_RD: state <= S_OBJ_GET;
        S_OBJ_GET: begin
          a_val <= 33'($signed(obj_rdata)) - 33'(shift_value);
          t_val <= (thr_mode == THR_OWN) ? $signed(var_rdata) : thr;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= (maximize ? b_val : a_val) * t_val;
          state <= S_TEST;
        end
        S_TEST: begin
          out_idx  <= OUT_IDX_W'(cidx);
          out_last <= last_c;
          out_pass <= pass;
          if (pass) begin
            acc   <= '0;
            sat   <= 1'b0;
            vidx  <= '0;
            state <= S_VB_RD;
          end else begin
            out_dist <= '0;
            state    <= S_OUT;
          end
        end
        S_VB_RD: state <= S_VC_RD;
        S_VC_RD: begin
          bvar  <= var_rdata;
          state <= S_VC_GET;
        end
        S_VC_GET: begin
          mag   <= diff[32] ? 32'(-diff) : diff[31:0];
          state <= S_SQ;
        end
        S_SQ: begin
          sq    <= 64'(mag) * 64'(mag);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_sum[63:0];
          sat <= sat | acc_sum[64];
          if (VW'(vidx) + VW'(1) == nvm1) begin
            state <= S_ROOT;
          end else begin
            vidx  <= vidx + PW'(1);
            state <= S_VB_RD;
          end
        end
        S_ROOT: begin
          if (sat) begin
            out_dist <= 32'hFFFF_FFFF;
            state    <= S_OUT;
          end else begin
            state <= S_ROOT_WAIT;
          end
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            out_dist <= root;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (out_last) begin
              count <= '0;
              tsum  <= '0;
              state <= S_LOAD;
            end else begin
              cidx  <= cidx + IW'(1);
              state <= S_OBJ_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {2'b00, out_dist, out_idx};
  assign m_tuser  = out_pass;
  assign m_tlast  = out_last;

endmodule
